// ===== src/kihh_pkg.sv =====
// kihh_pkg: shared types and constants of the keyed ipv6 host hash block
// depends on nothing; used by the channel interfaces and every module in src

package kihh_pkg;

    // field widths
    localparam int KEY_W   = 8;
    localparam int HASH_W  = 64;
    localparam int ADDR_W  = 128;
    localparam int HALF_W  = 64;
    localparam int PLEN_W  = 7;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 64;

    // fnv-1a constants
    localparam logic [HASH_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
    localparam logic [HASH_W-1:0] SEED_A    = 64'hcbf2_9ce4_8422_2325;
    localparam logic [HASH_W-1:0] SEED_B    = 64'h6c62_272e_07bb_0142;

    // register reset values
    localparam logic [HALF_W-1:0] PREFIX_HIGH_RST   = '0;
    localparam logic [HALF_W-1:0] PREFIX_LOW_RST    = '0;
    localparam logic [PLEN_W-1:0] PREFIX_LENGTH_RST = 7'd64;

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_PREFIX_HIGH   = 2'd0,
        REG_PREFIX_LOW    = 2'd1,
        REG_PREFIX_LENGTH = 2'd2
    } cfg_reg_t;

    // final hash pair of one key
    typedef struct packed {
        logic [HASH_W-1:0] hash_a;
        logic [HASH_W-1:0] hash_b;
    } hash_pair_t;

    // front to queue
    typedef struct packed {
        logic       push;
        hash_pair_t pair;
    } queue_push_t;

    // queue to back
    typedef struct packed {
        logic       valid;
        hash_pair_t pair;
    } queue_head_t;

endpackage

// ===== src/kihh_key_if.sv =====
// kihh_key_if: input channel carrying key bytes
// depends on kihh_pkg

interface kihh_key_if;
    logic                       valid;
    logic                       ready;
    logic [kihh_pkg::KEY_W-1:0] key_byte;
    logic                       key_end;

    modport source (output valid, output key_byte, output key_end, input ready);
    modport sink   (input valid, input key_byte, input key_end, output ready);
endinterface

// ===== src/kihh_addr_if.sv =====
// kihh_addr_if: output channel carrying address halves
// depends on kihh_pkg

interface kihh_addr_if;
    logic                        valid;
    logic                        ready;
    logic [kihh_pkg::HALF_W-1:0] address_half;
    logic                        is_low_half;

    modport source (output valid, output address_half, output is_low_half, input ready);
    modport sink   (input valid, input address_half, input is_low_half, output ready);
endinterface

// ===== src/kihh_cfg_if.sv =====
// kihh_cfg_if: configuration write channel (register index and data)
// depends on kihh_pkg

interface kihh_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [kihh_pkg::CIDX_W-1:0]  index;
    logic [kihh_pkg::CDATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/kihh_hash_front.sv =====
// kihh_hash_front: accepts key bytes and runs the two fnv-1a hashes
// depends on kihh_pkg and kihh_key_if; pushes finished hash pairs to kihh_queue

module kihh_hash_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    kihh_key_if.sink              key,
    input  logic                  queue_not_full,
    output kihh_pkg::queue_push_t push
);

    logic [kihh_pkg::HASH_W-1:0] hash_a_reg;
    logic [kihh_pkg::HASH_W-1:0] hash_a_next;
    logic [kihh_pkg::HASH_W-1:0] hash_b_reg;
    logic [kihh_pkg::HASH_W-1:0] hash_b_next;
    logic [kihh_pkg::HASH_W-1:0] absorbed_a;
    logic [kihh_pkg::HASH_W-1:0] absorbed_b;
    logic                        accept;

    // xor in the byte, then multiply by the prime 2^40 + 0x1b3 as shift-add
    function automatic logic [kihh_pkg::HASH_W-1:0] fnv_absorb(
        input logic [kihh_pkg::HASH_W-1:0] h,
        input logic [kihh_pkg::KEY_W-1:0]  b
    );
        logic [kihh_pkg::HASH_W-1:0] x;
        x = h ^ {{(kihh_pkg::HASH_W-kihh_pkg::KEY_W){1'b0}}, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    // a key byte is taken whenever the queue has room for a finished key
    assign key.ready = queue_not_full;
    assign accept    = key.valid && key.ready;

    assign absorbed_a = fnv_absorb(hash_a_reg, key.key_byte);
    assign absorbed_b = fnv_absorb(hash_b_reg, key.key_byte);

    // hand the final hashes to the queue on the last byte
    assign push.push        = accept && key.key_end;
    assign push.pair.hash_a = absorbed_a;
    assign push.pair.hash_b = absorbed_b;

    // next hash state: absorb, or back to seeds after the last byte
    always_comb
    begin
        hash_a_next = hash_a_reg;
        hash_b_next = hash_b_reg;
        if (accept)
        begin
            if (key.key_end)
            begin
                hash_a_next = kihh_pkg::SEED_A;
                hash_b_next = kihh_pkg::SEED_B;
            end
            else
            begin
                hash_a_next = absorbed_a;
                hash_b_next = absorbed_b;
            end
        end
    end

    // hash registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_a_reg <= kihh_pkg::SEED_A;
            hash_b_reg <= kihh_pkg::SEED_B;
        end
        else
        begin
            hash_a_reg <= hash_a_next;
            hash_b_reg <= hash_b_next;
        end
    end

    // the hashes restart from their seeds after a key ends
    a_seed_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && key.key_end) |=>
            (hash_a_reg == kihh_pkg::SEED_A && hash_b_reg == kihh_pkg::SEED_B))
        else $error("hashes not reseeded after key end");

    // no finished key is pushed into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> queue_not_full)
        else $error("key finished while queue full");

    // the hashes hold while no byte is taken
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> (hash_a_reg == $past(hash_a_reg) && hash_b_reg == $past(hash_b_reg)))
        else $error("hashes changed without a key beat");

endmodule

// ===== src/kihh_queue.sv =====
// kihh_queue: short fifo of finished hash pairs between front and back
// depends on kihh_pkg

module kihh_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  kihh_pkg::queue_push_t push,
    input  logic                  pop,
    output kihh_pkg::queue_head_t head,
    output logic                  not_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kihh_pkg::hash_pair_t slots_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign not_full   = (count_reg != CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.pair  = slots_reg[rd_ptr_reg];

    assign do_push = push.push && not_full;
    assign do_pop  = pop && head.valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push.pair;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> not_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

// ===== src/kihh_addr_back.sv =====
// kihh_addr_back: holds the prefix registers, builds the address and emits two halves
// depends on kihh_pkg, kihh_addr_if and kihh_cfg_if; pops hash pairs from kihh_queue

module kihh_addr_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  kihh_pkg::queue_head_t head,
    output logic                  pop,
    kihh_addr_if.source           addr,
    kihh_cfg_if.sink              cfg
);

    logic [kihh_pkg::HALF_W-1:0] prefix_high_reg;
    logic [kihh_pkg::HALF_W-1:0] prefix_low_reg;
    logic [kihh_pkg::PLEN_W-1:0] prefix_length_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        phase_reg;
    logic                        phase_next;
    logic [kihh_pkg::HALF_W-1:0] out_half_reg;
    logic                        out_low_reg;
    logic [kihh_pkg::ADDR_W-1:0] host_bits;
    logic [kihh_pkg::ADDR_W-1:0] prefix_mask;
    logic [kihh_pkg::ADDR_W-1:0] address;
    logic [kihh_pkg::PLEN_W-1:0] byte_shift;
    logic                        load;
    logic                        cfg_write;

    // host bits: hashes shifted right by whole prefix bytes
    assign byte_shift  = {prefix_length_reg[kihh_pkg::PLEN_W-1:3], 3'b000};
    assign host_bits   = {head.pair.hash_a, head.pair.hash_b} >> byte_shift;
    // top prefix_length bits come from the prefix
    assign prefix_mask = ~({kihh_pkg::ADDR_W{1'b1}} >> prefix_length_reg);
    assign address     = ({prefix_high_reg, prefix_low_reg} & prefix_mask)
                       | (host_bits & ~prefix_mask);

    // load a half when a pair waits and the output register is free or draining
    assign load = head.valid && (!out_valid_reg || addr.ready);
    assign pop  = load && phase_reg;

    assign addr.valid        = out_valid_reg;
    assign addr.address_half = out_half_reg;
    assign addr.is_low_half  = out_low_reg;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // output control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            phase_next     = ~phase_reg;
        end
        else if (addr.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            phase_reg         <= 1'b0;
            prefix_high_reg   <= kihh_pkg::PREFIX_HIGH_RST;
            prefix_low_reg    <= kihh_pkg::PREFIX_LOW_RST;
            prefix_length_reg <= kihh_pkg::PREFIX_LENGTH_RST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            if (cfg_write)
            begin
                unique case (cfg.index)
                    kihh_pkg::REG_PREFIX_HIGH:   prefix_high_reg   <= cfg.data;
                    kihh_pkg::REG_PREFIX_LOW:    prefix_low_reg    <= cfg.data;
                    kihh_pkg::REG_PREFIX_LENGTH:
                        prefix_length_reg <= cfg.data[kihh_pkg::PLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // output payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_half_reg <= phase_reg ? address[kihh_pkg::HALF_W-1:0]
                                      : address[kihh_pkg::ADDR_W-1:kihh_pkg::HALF_W];
            out_low_reg  <= phase_reg;
        end
    end

    // the low half follows the upper half right after its beat
    a_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (addr.valid && addr.ready && !addr.is_low_half) |=> (addr.valid && addr.is_low_half))
        else $error("low half missing after upper half");

    // a pair leaves the queue only with its low half
    a_pop_on_low: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (addr.valid && addr.is_low_half))
        else $error("pair popped without low half");

    a_plen_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg.index == kihh_pkg::REG_PREFIX_LENGTH) |=>
            (prefix_length_reg == $past(cfg.data[kihh_pkg::PLEN_W-1:0])))
        else $error("prefix length write lost");

endmodule

// ===== src/keyed_ipv6_host_hash_core.sv =====
// keyed_ipv6_host_hash_core: top level of the keyed ipv6 host address generator
// depends on kihh_pkg, the channel interfaces, kihh_hash_front, kihh_queue, kihh_addr_back
//
//   channel   dir   beat payload                      accepted when
//   key       in    key_byte[7:0], key_end            key.valid && key.ready
//   addr      out   address_half[63:0], is_low_half   addr.valid && addr.ready
//   cfg       in    index[1:0], data[63:0]            cfg.valid && cfg.ready
//
// one key byte per cycle while the queue has room; both 64-bit hashes update in one
// shift-add step in the front. each key yields two addr beats, upper half then lower half,
// from one output register; addr gives one beat per cycle while a pair waits and addr is ready.
// reset: hashes to their seeds, prefix 0, prefix length 64, queue and output empty.
// stalls: a held addr beat fills the queue; key.ready drops with QUEUE_DEPTH keys pending.
// cfg is always ready; write it only while no key is in flight (not enforced by the block).

module keyed_ipv6_host_hash_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    kihh_key_if.sink    key,
    kihh_addr_if.source addr,
    kihh_cfg_if.sink    cfg
);

    kihh_pkg::queue_push_t push;
    kihh_pkg::queue_head_t head;
    logic                  pop;
    logic                  queue_not_full;

    // front: byte intake and hashing
    kihh_hash_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .key            (key),
        .queue_not_full (queue_not_full),
        .push           (push)
    );

    // queue of finished hash pairs
    kihh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .head     (head),
        .not_full (queue_not_full)
    );

    // back: address build and output beats
    kihh_addr_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .addr  (addr),
        .cfg   (cfg)
    );

endmodule
